### rtl/cor_pkg.sv
package cor_pkg;

   // fixed width of the radius field
   localparam int RADIUS_BITS = 6;

   // decision variable constants of the midpoint rule
   localparam int DEC_INIT  = 3;
   localparam int DEC_INC_A = 6;
   localparam int DEC_INC_B = 10;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;
      logic out_free;
   } sts_type;

endpackage

### rtl/cor_ifs.sv
interface cor_req_if #(
   parameter int COORD_BITS = 12
);
   logic                                valid;
   logic                                ready;
   logic signed [COORD_BITS-1:0]        center_x;
   logic signed [COORD_BITS-1:0]        center_y;
   logic [cor_pkg::RADIUS_BITS-1:0]     radius;

   modport source (output valid, output center_x, output center_y, output radius,
                   input ready);
   modport sink (input valid, input center_x, input center_y, input radius,
                 output ready);
endinterface

interface cor_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS:0]   cx_plus_x;
   logic signed [COORD_BITS:0]   cx_minus_x;
   logic signed [COORD_BITS:0]   cx_plus_y;
   logic signed [COORD_BITS:0]   cx_minus_y;
   logic signed [COORD_BITS:0]   cy_plus_y;
   logic signed [COORD_BITS:0]   cy_minus_y;
   logic signed [COORD_BITS:0]   cy_plus_x;
   logic signed [COORD_BITS:0]   cy_minus_x;
   logic                         last_set;

   modport source (output valid, output cx_plus_x, output cx_minus_x, output cx_plus_y,
                   output cx_minus_y, output cy_plus_y, output cy_minus_y,
                   output cy_plus_x, output cy_minus_x, output last_set, input ready);
   modport sink (input valid, input cx_plus_x, input cx_minus_x, input cx_plus_y,
                 input cx_minus_y, input cy_plus_y, input cy_minus_y,
                 input cy_plus_x, input cy_minus_x, input last_set, output ready);
endinterface

### rtl/cor_ctrl.sv
module cor_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cor_pkg::sts_type  sts,
   output cor_pkg::cmd_type  cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_RUN  = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = sts.out_free;
            if (sts.out_free && sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RUN)
      else $error("circle did not start after load");

   a_load_step_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and step issued together");

endmodule

### rtl/cor_datapath.sv
module cor_datapath #(
   parameter int MAX_RADIUS = 63,
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cor_pkg::cmd_type                     cmd,
   output cor_pkg::sts_type                     sts,
   input  logic signed [COORD_BITS-1:0]         center_x,
   input  logic signed [COORD_BITS-1:0]         center_y,
   input  logic [cor_pkg::RADIUS_BITS-1:0]      radius,
   cor_rsp_if.source                            rsp_chan
);

   localparam int OFS_BITS = $clog2(MAX_RADIUS + 2);
   localparam int D_BITS   = OFS_BITS + 4;
   localparam int O_BITS   = COORD_BITS + 1;

   logic [OFS_BITS-1:0]          x_ff, x_in, y_ff, y_in, rad;
   logic signed [D_BITS-1:0]     d_ff, d_in, x_ext, y_ext, rad_ext;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [OFS_BITS:0]            x_inc;
   logic                         d_neg;
   logic signed [O_BITS-1:0]     cx_w, cy_w, xo, yo;

   logic signed [O_BITS-1:0]     cpx_ff, cmx_ff, cpy_ff, cmy_ff;
   logic signed [O_BITS-1:0]     ypy_ff, ymy_ff, ypx_ff, ymx_ff;
   logic                         last_ff;
   logic                         valid_ff, valid_in;

   always_comb begin
      rad = (int'(radius) > MAX_RADIUS) ? OFS_BITS'(MAX_RADIUS) : OFS_BITS'(radius);
      x_ext   = $signed(D_BITS'(x_ff));
      y_ext   = $signed(D_BITS'(y_ff));
      rad_ext = $signed(D_BITS'(rad));
      d_neg   = d_ff[D_BITS-1];
      x_inc   = (OFS_BITS + 1)'(x_ff) + (OFS_BITS + 1)'(1);

      // x > y after this step ends the octant
      sts.last     = d_neg ? (x_inc > (OFS_BITS + 1)'(y_ff))
                           : (x_inc >= (OFS_BITS + 1)'(y_ff));
      sts.out_free = !valid_ff || rsp_chan.ready;

      cx_w = O_BITS'(cx_ff);
      cy_w = O_BITS'(cy_ff);
      xo   = $signed(O_BITS'(x_ff));
      yo   = $signed(O_BITS'(y_ff));

      x_in = x_ff;
      y_in = y_ff;
      d_in = d_ff;
      if (cmd.load) begin
         x_in = '0;
         y_in = rad;
         d_in = D_BITS'(cor_pkg::DEC_INIT) - (rad_ext <<< 1);
      end else if (cmd.step) begin
         x_in = x_inc[OFS_BITS-1:0];
         if (d_neg) begin
            d_in = d_ff + (x_ext <<< 2) + D_BITS'(cor_pkg::DEC_INC_A);
         end else begin
            d_in = d_ff + ((x_ext - y_ext) <<< 2) + D_BITS'(cor_pkg::DEC_INC_B);
            y_in = y_ff - OFS_BITS'(1);
         end
      end

      valid_in = cmd.step ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      d_ff <= d_in;
      if (cmd.load) begin
         cx_ff <= center_x;
         cy_ff <= center_y;
      end
      if (cmd.step) begin
         cpx_ff  <= cx_w + xo;
         cmx_ff  <= cx_w - xo;
         cpy_ff  <= cx_w + yo;
         cmy_ff  <= cx_w - yo;
         ypy_ff  <= cy_w + yo;
         ymy_ff  <= cy_w - yo;
         ypx_ff  <= cy_w + xo;
         ymx_ff  <= cy_w - xo;
         last_ff <= sts.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.cx_plus_x  = cpx_ff;
   assign rsp_chan.cx_minus_x = cmx_ff;
   assign rsp_chan.cx_plus_y  = cpy_ff;
   assign rsp_chan.cx_minus_y = cmy_ff;
   assign rsp_chan.cy_plus_y  = ypy_ff;
   assign rsp_chan.cy_minus_y = ymy_ff;
   assign rsp_chan.cy_plus_x  = ypx_ff;
   assign rsp_chan.cy_minus_x = ymx_ff;
   assign rsp_chan.last_set   = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!valid_ff || rsp_chan.ready))
      else $error("pending word overwritten");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.last) |=> (rsp_chan.valid && rsp_chan.last_set))
      else $error("final word not flagged");

   a_load_origin: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (x_ff == '0 && y_ff <= OFS_BITS'(MAX_RADIUS)))
      else $error("bad starting offsets");

endmodule

### rtl/circle_octant_rasterizer_top.sv
// circle octant rasterizer, midpoint circle decision rule in pixel units
//
// req_chan carries one circle: center_x, center_y (two's complement) and
// radius; a radius above MAX_RADIUS is clamped to MAX_RADIUS. rsp_chan returns
// one word per octant step with the eight mirrored coordinates; the final word
// of a circle has last_set high. radius zero gives one word at the center.
//
// the first word is registered by the step after the load, which waits while
// an earlier word is pending. throughput: one word per cycle while rsp_chan
// is ready; a circle of radius r gives about r/sqrt(2)+1 words (45 for
// radius 63), and req_chan.ready returns once the last step is taken. the
// single step unit of the datapath (one decision update per cycle) sets this.
//
// a stalled receiver holds the output register and freezes the stepper; no
// word is dropped. the next request may be taken while the last word waits.
// synchronous reset returns the controller to idle and empties the output.
module circle_octant_rasterizer_top #(
   parameter int MAX_RADIUS = 63,
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   cor_req_if.sink     req_chan,
   cor_rsp_if.source   rsp_chan
);

   // command and status between controller and datapath
   cor_pkg::cmd_type cmd;
   cor_pkg::sts_type sts;

   // sequencer: idle / run, issues load and step
   cor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // offsets, decision variable, held center and output word register
   cor_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .center_x (req_chan.center_x),
      .center_y (req_chan.center_y),
      .radius   (req_chan.radius),
      .rsp_chan (rsp_chan)
   );

endmodule
